### design/scl_pkg.sv
package scl_pkg;

  // line store
  localparam int LINE_CAPACITY = 16;
  localparam int IDX_W = $clog2(LINE_CAPACITY);
  localparam int LEN_W = $clog2(LINE_CAPACITY + 1);

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQUENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQUENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY_STEP = 2'd2;
  localparam logic [15:0] MIN_FREQUENCY_RESET = 16'd200;
  localparam logic [15:0] MAX_FREQUENCY_RESET = 16'd10000;
  localparam logic [15:0] FREQUENCY_STEP_RESET = 16'd100;

  // characters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_F = "f";
  localparam logic [7:0] CHAR_SPACE = " ";
  localparam logic [7:0] CHAR_ZERO = "0";
  localparam logic [7:0] CHAR_NINE = "9";
  localparam logic [7:0] CHAR_UPPER_A = "A";
  localparam logic [7:0] CHAR_UPPER_Z = "Z";
  localparam logic [7:0] CASE_BIT = 8'h20;

  // outcome codes
  localparam logic [3:0] CMD_ON = 4'd0;
  localparam logic [3:0] CMD_OFF = 4'd1;
  localparam logic [3:0] CMD_RESET = 4'd2;
  localparam logic [3:0] CMD_SWEEP5 = 4'd3;
  localparam logic [3:0] CMD_SWEEP10 = 4'd4;
  localparam logic [3:0] CMD_SWEEP15 = 4'd5;
  localparam logic [3:0] CMD_SETFREQ = 4'd6;
  localparam logic [3:0] CMD_UNKNOWN = 4'd7;
  localparam logic [3:0] CMD_RANGE = 4'd8;
  localparam logic [3:0] CMD_STEP = 4'd9;
  localparam logic [3:0] CMD_LONG = 4'd10;
  localparam logic [3:0] CMD_NONE = 4'd0;

  // fixed command words, padded with zero bytes
  localparam int NUM_WORDS = 6;
  localparam int WORD_MAX = 8;
  localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_MAX] = '{
    '{"o", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "f", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "s", "e", "t", 8'h00, 8'h00, 8'h00},
    '{"s", "w", "e", "e", "p", " ", "5", 8'h00},
    '{"s", "w", "e", "e", "p", " ", "1", "0"},
    '{"s", "w", "e", "e", "p", " ", "1", "5"}
  };
  localparam logic [LEN_W-1:0] WORD_LEN [NUM_WORDS] = '{
    LEN_W'(2), LEN_W'(3), LEN_W'(5), LEN_W'(7), LEN_W'(8), LEN_W'(8)
  };
  localparam logic [3:0] WORD_CODE [NUM_WORDS] = '{
    CMD_ON, CMD_OFF, CMD_RESET, CMD_SWEEP5, CMD_SWEEP10, CMD_SWEEP15
  };

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_CHECK = 6'b001000,
    S_MOD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

### design/scl_if.sv
interface scl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface scl_res_if;
  logic        valid;
  logic        ready;
  logic        echo_valid;
  logic [7:0]  echo_char;
  logic        command_valid;
  logic [3:0]  command_code;
  logic [15:0] frequency_value;

  modport source (
    output valid, output echo_valid, output echo_char, output command_valid,
    output command_code, output frequency_value, input ready
  );
  modport sink (
    input valid, input echo_valid, input echo_char, input command_valid,
    input command_code, input frequency_value, output ready
  );
endinterface

### design/scl_ram.sv
module scl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/serial_command_line_decoder.sv
// channel | dir | payload                                               | handshake
// rx      | in  | rx_char                                               | valid/ready
// res     | out | echo_valid echo_char command_valid command_code       | valid/ready
//         |     | frequency_value                                       |
// cfg     | in  | cfg_index cfg_data                                    | cfg_we
//
// an ordinary character is handled in idle without a walk of the line; so is a carriage return on an empty line
// a carriage return on a line of n characters walks the line buffer, then runs the
// step check when the frequency passes the range check and the step is non-zero
// (one buffer read and one compare per character, one remainder bit per cycle)
// reset (rst, synchronous) empties the line and restores the register defaults
// the result sits in an output register; rx is ready only in idle, and then only
// while that register is empty or being taken in the same cycle
module serial_command_line_decoder (
  input  logic                            clk,
  input  logic                            rst,
  scl_rx_if.sink                          rx,
  scl_res_if.source                       res,
  input  logic                            cfg_we,
  input  logic [scl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [15:0] min_frequency;
  logic [15:0] max_frequency;
  logic [15:0] frequency_step;

  // sequencer and line state
  scl_pkg::state_t             state;
  logic [scl_pkg::LEN_W-1:0]   line_length;
  logic                        out_valid;

  // walk datapath
  logic [scl_pkg::IDX_W-1:0]       idx;
  logic [scl_pkg::NUM_WORDS-1:0]   word_match;
  logic                            pref_f;
  logic                            pref_sp;
  logic                            bad_digit;
  logic [15:0]                     value;
  logic [15:0]                     rem;
  logic [15:0]                     dvd;
  logic [3:0]                      bit_cnt;
  logic [3:0]                      result_code;

  // output register
  logic        echo_valid_q;
  logic [7:0]  echo_char_q;
  logic        command_valid_q;
  logic [3:0]  command_code_q;
  logic [15:0] frequency_value_q;

  // line buffer
  logic                      buf_we;
  logic [7:0]                buf_wdata;
  logic [7:0]                buf_rdata;

  logic out_free;
  logic rx_accept;
  logic is_cr;
  logic line_full;
  logic last_char;
  logic is_f;
  logic [7:0] digit;
  logic [19:0] value_mac;
  logic [15:0] value_sat;
  logic [16:0] trial;
  logic [15:0] rem_next;
  logic [scl_pkg::NUM_WORDS-1:0] word_hit;
  logic [3:0] word_result;

  assign out_free  = !out_valid || res.ready;
  assign rx.ready  = (state == scl_pkg::S_IDLE) && out_free;
  assign rx_accept = rx.valid && rx.ready;
  assign is_cr     = (rx.rx_char == scl_pkg::CHAR_CR);
  assign line_full = (line_length + scl_pkg::LEN_W'(1)) == scl_pkg::LEN_W'(scl_pkg::LINE_CAPACITY);
  assign last_char = (scl_pkg::LEN_W'(idx) + scl_pkg::LEN_W'(1)) == line_length;
  assign is_f      = pref_f && pref_sp && (line_length >= scl_pkg::LEN_W'(2));

  // fold upper case letters before storing
  always_comb begin
    buf_wdata = rx.rx_char;
    if (rx.rx_char >= scl_pkg::CHAR_UPPER_A && rx.rx_char <= scl_pkg::CHAR_UPPER_Z) begin
      buf_wdata = rx.rx_char | scl_pkg::CASE_BIT;
    end
  end
  assign buf_we = rx_accept && !is_cr;

  scl_ram #(
    .WIDTH (8),
    .DEPTH (scl_pkg::LINE_CAPACITY)
  ) u_line_buffer (
    .clk   (clk),
    .we    (buf_we),
    .waddr (line_length[scl_pkg::IDX_W-1:0]),
    .wdata (buf_wdata),
    .raddr (idx),
    .rdata (buf_rdata)
  );

  // decimal accumulate with saturation at 65535
  assign digit     = buf_rdata - scl_pkg::CHAR_ZERO;
  assign value_mac = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {12'd0, digit};
  assign value_sat = (value_mac > 20'hFFFF) ? 16'hFFFF : value_mac[15:0];

  // one restoring step of the remainder unit
  assign trial    = {rem, dvd[15]};
  assign rem_next = (trial >= {1'b0, frequency_step}) ?
                    16'(trial - {1'b0, frequency_step}) : trial[15:0];

  // first fixed word that matches the whole line
  always_comb begin
    word_result = scl_pkg::CMD_UNKNOWN;
    for (int w = 0; w < scl_pkg::NUM_WORDS; w++) begin
      word_hit[w] = word_match[w] && (line_length == scl_pkg::WORD_LEN[w]);
    end
    for (int w = scl_pkg::NUM_WORDS - 1; w >= 0; w--) begin
      if (word_hit[w]) begin
        word_result = scl_pkg::WORD_CODE[w];
      end
    end
  end

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      min_frequency  <= scl_pkg::MIN_FREQUENCY_RESET;
      max_frequency  <= scl_pkg::MAX_FREQUENCY_RESET;
      frequency_step <= scl_pkg::FREQUENCY_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scl_pkg::CFG_MIN_FREQUENCY:  min_frequency  <= cfg_data;
        scl_pkg::CFG_MAX_FREQUENCY:  max_frequency  <= cfg_data;
        scl_pkg::CFG_FREQUENCY_STEP: frequency_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, line length and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= scl_pkg::S_IDLE;
      line_length <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        scl_pkg::S_IDLE: begin
          if (rx_accept) begin
            if (is_cr) begin
              if (line_length == '0) begin
                out_valid <= 1'b1;
              end else begin
                state <= scl_pkg::S_READ;
              end
            end else begin
              out_valid <= 1'b1;
              if (line_full) begin
                line_length <= '0;
              end else begin
                line_length <= line_length + scl_pkg::LEN_W'(1);
              end
            end
          end
        end
        scl_pkg::S_READ: state <= scl_pkg::S_EVAL;
        scl_pkg::S_EVAL: begin
          state <= last_char ? scl_pkg::S_CHECK : scl_pkg::S_READ;
        end
        scl_pkg::S_CHECK: begin
          if (is_f && !bad_digit && value >= min_frequency && value <= max_frequency &&
              frequency_step != '0) begin
            state <= scl_pkg::S_MOD;
          end else begin
            state <= scl_pkg::S_DONE;
          end
        end
        scl_pkg::S_MOD: begin
          if (bit_cnt == 4'd15) begin
            state <= scl_pkg::S_DONE;
          end
        end
        scl_pkg::S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            line_length <= '0;
            state       <= scl_pkg::S_IDLE;
          end
        end
        default: state <= scl_pkg::S_IDLE;
      endcase
    end
  end

  // walk datapath and output payload
  always_ff @(posedge clk) begin
    case (state)
      scl_pkg::S_IDLE: begin
        idx        <= '0;
        word_match <= '1;
        pref_f     <= 1'b0;
        pref_sp    <= 1'b0;
        bad_digit  <= 1'b0;
        value      <= '0;
        if (rx_accept) begin
          echo_valid_q      <= !is_cr;
          echo_char_q       <= is_cr ? 8'h00 : rx.rx_char;
          command_valid_q   <= !is_cr && line_full;
          command_code_q    <= (!is_cr && line_full) ? scl_pkg::CMD_LONG : scl_pkg::CMD_NONE;
          frequency_value_q <= '0;
        end
      end
      scl_pkg::S_EVAL: begin
        // buffer data for idx is valid here
        if (idx == scl_pkg::IDX_W'(0)) begin
          pref_f <= (buf_rdata == scl_pkg::CHAR_F);
        end
        if (idx == scl_pkg::IDX_W'(1)) begin
          pref_sp <= (buf_rdata == scl_pkg::CHAR_SPACE);
        end
        if (idx >= scl_pkg::IDX_W'(2)) begin
          if (buf_rdata < scl_pkg::CHAR_ZERO || buf_rdata > scl_pkg::CHAR_NINE) begin
            bad_digit <= 1'b1;
          end else begin
            value <= value_sat;
          end
        end
        for (int w = 0; w < scl_pkg::NUM_WORDS; w++) begin
          if (scl_pkg::LEN_W'(idx) >= scl_pkg::WORD_LEN[w] ||
              buf_rdata != scl_pkg::WORD_TEXT[w][idx[2:0]]) begin
            word_match[w] <= 1'b0;
          end
        end
        if (!last_char) begin
          idx <= idx + scl_pkg::IDX_W'(1);
        end
      end
      scl_pkg::S_CHECK: begin
        rem     <= '0;
        dvd     <= value;
        bit_cnt <= '0;
        if (is_f) begin
          if (bad_digit) begin
            result_code <= scl_pkg::CMD_UNKNOWN;
          end else if (value < min_frequency || value > max_frequency) begin
            result_code <= scl_pkg::CMD_RANGE;
          end else begin
            result_code <= scl_pkg::CMD_SETFREQ;
          end
        end else begin
          result_code <= word_result;
        end
      end
      scl_pkg::S_MOD: begin
        rem     <= rem_next;
        dvd     <= {dvd[14:0], 1'b0};
        bit_cnt <= bit_cnt + 4'd1;
        if (bit_cnt == 4'd15 && rem_next != '0) begin
          result_code <= scl_pkg::CMD_STEP;
        end
      end
      scl_pkg::S_DONE: begin
        if (out_free) begin
          echo_valid_q      <= 1'b0;
          echo_char_q       <= 8'h00;
          command_valid_q   <= 1'b1;
          command_code_q    <= result_code;
          frequency_value_q <= (result_code == scl_pkg::CMD_SETFREQ) ? value : 16'd0;
        end
      end
      default: ;
    endcase
  end

  assign res.valid           = out_valid;
  assign res.echo_valid      = echo_valid_q;
  assign res.echo_char       = echo_char_q;
  assign res.command_valid   = command_valid_q;
  assign res.command_code    = command_code_q;
  assign res.frequency_value = frequency_value_q;

endmodule
